/* hdl/nsv_pkg.sv */
package nsv_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  localparam logic [7:0] MIN_LEN      = 8'd9;
  localparam logic [7:0] LEN_SAT      = 8'd255;
  localparam logic [7:0] HDR_LAST_POS = 8'd6;
  localparam logic [7:0] MAX_LEN_RST  = 8'd82;

  localparam int HIST_DEPTH = 4;

  // sentence queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [0:0] {
    REG_CSUM_ENABLE = 1'b0,
    REG_MAX_LENGTH  = 1'b1
  } cfg_reg_t;

  // per-sentence summary handed from front to back
  typedef struct packed {
    logic [7:0] len;
    logic       header_ok;
    logic       crlf_ok;
    logic       present;
    logic [7:0] xor_sum;
    logic [7:0] hex_hi;
    logic [7:0] hex_lo;
  } sentence_t;

  // bit 4 flags a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  // strtol-style read of two characters, low byte kept
  function automatic logic [7:0] read_hex2(input logic [7:0] c0, input logic [7:0] c1);
    logic [4:0] h0;
    logic [4:0] h1;
    logic [7:0] r;
    h0 = hex_value(c0);
    h1 = hex_value(c1);
    r  = 8'd0;
    if (h0[4]) begin
      r = h1[4] ? {h0[3:0], h1[3:0]} : {4'd0, h0[3:0]};
    end else if (is_blank(c0) || c0 == CH_PLUS) begin
      r = h1[4] ? {4'd0, h1[3:0]} : 8'd0;
    end else if (c0 == CH_MINUS) begin
      r = h1[4] ? (8'd0 - {4'd0, h1[3:0]}) : 8'd0;
    end
    return r;
  endfunction

endpackage

/* hdl/nmea_sentence_validator.sv */
// channel   direction  handshake            payload
// input     in         push / full          char_byte, end_of_sentence
// result    out        empty / pop          sentence_valid, checksum_present, computed_checksum
// config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// One byte is taken per cycle while full is low; a sentence's verdict passes a queue slot
// and then the output register. The front scanner keeps the per-sentence state,
// a two-entry sentence queue feeds the verdict stage, whose output register waits for pop.
// full rises only when both queue slots hold sentences the output side has not taken.
// Reset (rst, synchronous) clears the sentence state and restores the register defaults.
module nmea_sentence_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_byte,
  input  logic       end_of_sentence,
  output logic       empty,
  input  logic       pop,
  output logic       sentence_valid,
  output logic       checksum_present,
  output logic [7:0] computed_checksum,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import nsv_pkg::*;

  sentence_t wr_rec;
  sentence_t rd_rec;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  nsv_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .char_byte       (char_byte),
    .end_of_sentence (end_of_sentence),
    .q_full          (q_full),
    .full            (full),
    .q_push          (q_push),
    .q_data          (wr_rec)
  );

  nsv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (wr_rec),
    .rd_en   (q_pop),
    .rd_data (rd_rec),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  nsv_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_empty           (q_empty),
    .q_data            (rd_rec),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .sentence_valid    (sentence_valid),
    .checksum_present  (checksum_present),
    .computed_checksum (computed_checksum)
  );

endmodule

/* hdl/nsv_front.sv */
module nsv_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          char_byte,
  input  logic                end_of_sentence,
  input  logic                q_full,
  output logic                full,
  output logic                q_push,
  output nsv_pkg::sentence_t  q_data
);
  import nsv_pkg::*;

  logic [7:0] byte_position, byte_position_next;
  logic [7:0] running_xor, running_xor_next;
  logic       xor_stopped, xor_stopped_next;
  logic       header_ok, header_ok_next;
  logic [7:0] recent_bytes [HIST_DEPTH];
  logic       accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && end_of_sentence;

  always_comb begin
    header_ok_next = header_ok;
    if (byte_position == 8'd0) begin
      if (char_byte != CH_DOLLAR) header_ok_next = 1'b0;
    end else if (byte_position < HDR_LAST_POS) begin
      if (!(char_byte inside {[CH_UPPER_A:CH_UPPER_Z]})) header_ok_next = 1'b0;
    end else if (byte_position == HDR_LAST_POS) begin
      if (char_byte != CH_COMMA) header_ok_next = 1'b0;
    end

    running_xor_next = running_xor;
    xor_stopped_next = xor_stopped;
    if (byte_position != 8'd0 && !xor_stopped) begin
      if (char_byte == CH_STAR || char_byte == CH_CR || char_byte == 8'd0) begin
        xor_stopped_next = 1'b1;
      end else begin
        running_xor_next = running_xor ^ char_byte;
      end
    end

    byte_position_next = (byte_position == LEN_SAT) ? byte_position : byte_position + 8'd1;
  end

  always_comb begin
    q_data.len       = byte_position_next;
    q_data.header_ok = header_ok_next;
    q_data.crlf_ok   = (char_byte == CH_LF) && (recent_bytes[0] == CH_CR);
    q_data.present   = recent_bytes[3] == CH_STAR;
    q_data.xor_sum   = running_xor_next;
    q_data.hex_hi    = recent_bytes[2];
    q_data.hex_lo    = recent_bytes[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_xor   <= '0;
      xor_stopped   <= 1'b0;
      header_ok     <= 1'b1;
      for (int i = 0; i < HIST_DEPTH; i++) recent_bytes[i] <= '0;
    end else if (accept) begin
      if (end_of_sentence) begin
        byte_position <= '0;
        running_xor   <= '0;
        xor_stopped   <= 1'b0;
        header_ok     <= 1'b1;
        for (int i = 0; i < HIST_DEPTH; i++) recent_bytes[i] <= '0;
      end else begin
        byte_position <= byte_position_next;
        running_xor   <= running_xor_next;
        xor_stopped   <= xor_stopped_next;
        header_ok     <= header_ok_next;
        recent_bytes[0] <= char_byte;
        for (int i = 1; i < HIST_DEPTH; i++) recent_bytes[i] <= recent_bytes[i-1];
      end
    end
  end

endmodule

/* hdl/nsv_queue.sv */
module nsv_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  nsv_pkg::sentence_t  wr_data,
  input  logic                rd_en,
  output nsv_pkg::sentence_t  rd_data,
  output logic                q_full,
  output logic                q_empty
);
  import nsv_pkg::*;

  sentence_t        slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;

  assign q_full  = count == QCW'(QDEPTH);
  assign q_empty = count == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/nsv_back.sv */
module nsv_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                q_empty,
  input  nsv_pkg::sentence_t  q_data,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic                sentence_valid,
  output logic                checksum_present,
  output logic [7:0]          computed_checksum
);
  import nsv_pkg::*;

  logic       csum_enable;
  logic [7:0] max_length;
  logic       out_valid;
  logic       verdict;
  logic [7:0] given_sum;

  assign empty = !out_valid;
  assign q_pop = !q_empty && (!out_valid || pop);

  always_comb begin
    given_sum = read_hex2(q_data.hex_hi, q_data.hex_lo);
    verdict   = q_data.header_ok && q_data.crlf_ok;
    if (q_data.len < MIN_LEN || q_data.len == LEN_SAT || q_data.len > max_length) begin
      verdict = 1'b0;
    end
    if (csum_enable && q_data.present && given_sum != q_data.xor_sum) begin
      verdict = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      csum_enable <= 1'b1;
      max_length  <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CSUM_ENABLE: csum_enable <= cfg_data[0];
        REG_MAX_LENGTH:  max_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sentence_valid    <= verdict;
      checksum_present  <= q_data.present;
      computed_checksum <= q_data.xor_sum;
    end
  end

endmodule

/* dv/tb_nmea_sentence_validator.sv */
module tb_nmea_sentence_validator;
  timeunit 1ns;
  timeprecision 1ps;

  import nsv_pkg::*;

  typedef logic [7:0] byte_t;

  typedef struct {
    byte_t ch;
    logic  last;
  } char_item_t;

  typedef struct {
    logic  valid;
    logic  present;
    byte_t xsum;
  } verdict_t;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  byte_t      char_byte = '0;
  logic       end_of_sentence = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       sentence_valid;
  logic       checksum_present;
  byte_t      computed_checksum;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  byte_t      cfg_data = '0;

  nmea_sentence_validator uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .char_byte(char_byte),
    .end_of_sentence(end_of_sentence),
    .empty(empty),
    .pop(pop),
    .sentence_valid(sentence_valid),
    .checksum_present(checksum_present),
    .computed_checksum(computed_checksum),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  char_item_t pending_bytes[$];
  verdict_t   due_verdicts[$];
  byte_t      snt[$];

  // local copy of the sentence scanner and its registers
  byte_t             scan_pos = '0;
  byte_t             scan_xor = '0;
  logic              scan_halted = 1'b0;
  logic              scan_hdr_ok = 1'b1;
  logic [3:0][7:0]   scan_hist = '0;
  logic              cfg_check = 1'b1;
  byte_t             cfg_max_len = MAX_LEN_RST;

  int   errors = 0;
  int   quiet_cycles = 0;
  int   queued_bytes = 0;
  int   send_idle_pct = 0;
  int   pop_stall_pct = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  logic in_fire = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int digit_val(byte_t c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
    return -1;
  endfunction

  // strtol on two characters, low byte kept
  function automatic byte_t hex_pair(byte_t c0, byte_t c1);
    int d0;
    int d1;
    d0 = digit_val(c0);
    d1 = digit_val(c1);
    if (d0 >= 0) return (d1 >= 0) ? byte_t'(d0 * 16 + d1) : byte_t'(d0);
    if (c0 == CH_SPACE || (c0 >= 8'h09 && c0 <= CH_CR) || c0 == CH_PLUS)
      return (d1 >= 0) ? byte_t'(d1) : 8'h00;
    if (c0 == CH_MINUS && d1 >= 0) return byte_t'(-d1);
    return 8'h00;
  endfunction

  task automatic scan_byte(input byte_t c, input logic last);
    verdict_t v;
    if (scan_pos == 0) begin
      if (c != CH_DOLLAR) scan_hdr_ok = 1'b0;
    end else if (scan_pos < HDR_LAST_POS) begin
      if (c < CH_UPPER_A || c > CH_UPPER_Z) scan_hdr_ok = 1'b0;
    end else if (scan_pos == HDR_LAST_POS) begin
      if (c != CH_COMMA) scan_hdr_ok = 1'b0;
    end
    if (scan_pos != 0 && !scan_halted) begin
      if (c == CH_STAR || c == CH_CR || c == 8'h00) scan_halted = 1'b1;
      else scan_xor ^= c;
    end
    if (scan_pos != LEN_SAT) scan_pos++;
    if (!last) begin
      scan_hist = {scan_hist[2:0], c};
    end else begin
      v.present = (scan_hist[3] == CH_STAR);
      v.valid = scan_hdr_ok && scan_pos >= MIN_LEN && scan_pos != LEN_SAT
                && scan_pos <= cfg_max_len && c == CH_LF && scan_hist[0] == CH_CR
                && !(cfg_check && v.present && hex_pair(scan_hist[2], scan_hist[1]) != scan_xor);
      v.xsum = scan_xor;
      due_verdicts.push_back(v);
      scan_pos = '0;
      scan_xor = '0;
      scan_halted = 1'b0;
      scan_hdr_ok = 1'b1;
      scan_hist = '0;
    end
  endtask

  // sentence construction

  function automatic byte_t body_char();
    byte_t c;
    do c = byte_t'($urandom_range(8'h20, 8'hFF)); while (c == CH_STAR);
    return c;
  endfunction

  function automatic byte_t hex_char(byte_t nib);
    if (nib < 10) return 8'h30 + nib;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + nib - 10;
  endfunction

  function automatic byte_t not_hex();
    return $urandom_range(1) ? byte_t'($urandom_range(8'h47, 8'h5A))
                             : byte_t'($urandom_range(8'h67, 8'h7A));
  endfunction

  function automatic void close_sentence(bit with_cs);
    byte_t x;
    x = '0;
    for (int i = 1; i < snt.size(); i++) x ^= snt[i];
    if (with_cs) begin
      snt.push_back(CH_STAR);
      snt.push_back(hex_char(x[7:4]));
      snt.push_back(hex_char(x[3:0]));
    end
    snt.push_back(CH_CR);
    snt.push_back(CH_LF);
  endfunction

  function automatic void make_sentence(int body_len, bit with_cs);
    snt.delete();
    snt.push_back(CH_DOLLAR);
    repeat (5) snt.push_back(byte_t'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
    snt.push_back(CH_COMMA);
    repeat (body_len) snt.push_back(body_char());
    close_sentence(with_cs);
  endfunction

  // rewrite the last two body bytes so the running XOR ends at t
  function automatic void force_xor(byte_t t);
    int    star;
    byte_t k;
    byte_t a;
    byte_t b;
    star = snt.size() - 5;
    k = t;
    for (int i = 1; i < star - 2; i++) k ^= snt[i];
    do begin
      a = body_char();
      b = a ^ k;
    end while (b < CH_SPACE || b == CH_STAR);
    snt[star - 2] = a;
    snt[star - 1] = b;
  endfunction

  // checksum text that strtol reads in an unusual way
  function automatic void make_odd_checksum(int form);
    byte_t h;
    byte_t c0;
    byte_t c1;
    byte_t t;
    h = byte_t'($urandom_range(15));
    make_sentence($urandom_range(2, 4), 1);
    case (form)
      0: begin
        c0 = CH_SPACE; c1 = hex_char(h); t = h;
      end
      1: begin
        c0 = byte_t'($urandom_range(8'h09, CH_CR)); c1 = hex_char(h); t = h;
      end
      2: begin
        c0 = CH_PLUS; c1 = hex_char(h); t = h;
      end
      3: begin
        c0 = CH_MINUS; c1 = hex_char(h); t = 8'h00 - h;
      end
      4: begin
        c0 = hex_char(h); c1 = not_hex(); t = h;
      end
      5: begin
        c0 = not_hex(); c1 = hex_char(h); t = '0;
      end
      default: begin
        c0 = $urandom_range(1) ? CH_MINUS : CH_SPACE; c1 = not_hex(); t = '0;
      end
    endcase
    if ($urandom_range(3) == 0) t ^= 8'h01;
    force_xor(t);
    snt[snt.size() - 4] = c0;
    snt[snt.size() - 3] = c1;
  endfunction

  function automatic void make_random_sentence();
    int r;
    int n;
    int bl;
    r = $urandom_range(99);
    if (r < 45) begin
      make_sentence($urandom_range(0, 20), $urandom_range(1));
    end else if (r < 55) begin
      make_odd_checksum($urandom_range(6));
    end else if (r < 65) begin
      make_sentence($urandom_range(0, 20), 1);
      snt[snt.size() - 3] ^= 8'h01;
    end else if (r < 75) begin
      make_sentence($urandom_range(0, 20), $urandom_range(1));
      snt[$urandom_range(snt.size() - 1)] = byte_t'($urandom_range(255));
    end else if (r < 80) begin
      make_sentence($urandom_range(0, 20), $urandom_range(1));
      snt.delete($urandom_range(snt.size() - 1));
    end else if (r < 85) begin
      make_sentence($urandom_range(1, 20), $urandom_range(1));
      n = snt.size();
      snt[$urandom_range(1, n - 3)] = $urandom_range(1) ? 8'h00 : CH_CR;
    end else if (r < 90) begin
      snt.delete();
      repeat ($urandom_range(1, 20)) snt.push_back(byte_t'($urandom_range(255)));
    end else if (r < 95) begin
      make_sentence($urandom_range(0, 5), 0);
      snt = snt[0:$urandom_range(7)];
    end else begin
      // around the configured length limit, only when that limit is short
      bl = (cfg_max_len <= MAX_LEN_RST) ? int'(cfg_max_len) - 10 + $urandom_range(2)
                                        : $urandom_range(20);
      if (bl < 0) bl = 0;
      make_sentence(bl, 0);
    end
  endfunction

  function automatic void queue_sentence();
    char_item_t it;
    foreach (snt[i]) begin
      it.ch = snt[i];
      it.last = (i == snt.size() - 1);
      pending_bytes.push_back(it);
    end
    queued_bytes += snt.size();
  endfunction

  task automatic queue_random(int min_bytes);
    int first;
    int count;
    first = queued_bytes;
    count = 0;
    while (queued_bytes - first < min_bytes || count < 2) begin
      make_random_sentence();
      queue_sentence();
      count++;
    end
  endtask

  task automatic drain();
    do @(posedge clk); while (pending_bytes.size() != 0 || due_verdicts.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input byte_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CSUM_ENABLE: cfg_check = val[0];
      REG_MAX_LENGTH:  cfg_max_len = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // byte sender
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (in_fire) pending_bytes.pop_front();
      if (push && !in_fire) begin
        push <= 1'b1;
      end else if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        char_byte <= pending_bytes[0].ch;
        end_of_sentence <= pending_bytes[0].last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // verdict receiver
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    in_fire <= !rst && push && !full;
    if (!rst && pop && !empty) begin
      if (due_verdicts.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected: valid %0b present %0b checksum %02h",
                 $time, sentence_valid, checksum_present, computed_checksum);
      end else begin
        v = due_verdicts.pop_front();
        if (sentence_valid !== v.valid) begin
          errors++;
          $display("%0t: sentence_valid expected %0b actual %0b",
                   $time, v.valid, sentence_valid);
        end
        if (checksum_present !== v.present) begin
          errors++;
          $display("%0t: checksum_present expected %0b actual %0b",
                   $time, v.present, checksum_present);
        end
        if (computed_checksum !== v.xsum) begin
          errors++;
          $display("%0t: computed_checksum expected %02h actual %02h",
                   $time, v.xsum, computed_checksum);
        end
      end
    end
    if (!rst && push && !full) scan_byte(char_byte, end_of_sentence);
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    int n;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset settings, no idling, then a long receiver hold-off
    send_idle_pct = 0;
    pop_stall_pct = 0;
    make_sentence(10, 1); queue_sentence();
    snt = '{CH_DOLLAR, CH_UPPER_A, CH_UPPER_Z, CH_UPPER_A, CH_UPPER_Z, CH_UPPER_Z,
            CH_COMMA, CH_SPACE, 8'hFF};
    close_sentence(1); queue_sentence();
    make_sentence(0, 0); queue_sentence();
    make_sentence(74, 0); queue_sentence();
    make_sentence(8, 1); snt[snt.size() - 3] ^= 8'h01; queue_sentence();
    make_sentence(5, 0); snt[0] = CH_STAR; queue_sentence();
    make_sentence(5, 0); snt[3] = 8'h61; queue_sentence();
    make_sentence(5, 0); snt[2] = 8'h5B; snt[4] = 8'h40; queue_sentence();
    make_sentence(5, 0); snt[6] = 8'h3B; queue_sentence();
    make_sentence(5, 1); snt.delete(snt.size() - 2); queue_sentence();
    make_sentence(5, 1); snt[snt.size() - 1] = 8'h0B; queue_sentence();
    for (int f = 0; f < 7; f++) begin
      make_odd_checksum(f); queue_sentence();
    end
    make_sentence(6, 1); snt[9] = 8'h00; queue_sentence();
    // no stop byte anywhere after the dollar
    make_sentence(4, 0); n = snt.size(); snt[n - 2] = 8'hFF; queue_sentence();
    snt = '{CH_LF}; queue_sentence();
    snt = '{CH_DOLLAR, CH_STAR, CH_CR, CH_LF}; queue_sentence();
    hold_req++;
    drain();

    // checking off, longest limit, sender mostly idle
    write_reg(REG_CSUM_ENABLE, 8'h00);
    write_reg(REG_MAX_LENGTH, 8'hFF);
    send_idle_pct = 85;
    pop_stall_pct = 0;
    make_sentence(246, 0); queue_sentence();
    make_sentence(8, 1); snt[snt.size() - 3] ^= 8'h01; queue_sentence();
    drain();

    // shortest limit, receiver mostly stalled
    write_reg(REG_CSUM_ENABLE, 8'h01);
    write_reg(REG_MAX_LENGTH, MIN_LEN);
    send_idle_pct = 0;
    pop_stall_pct = 85;
    make_sentence(0, 0); queue_sentence();
    make_sentence(1, 0); queue_sentence();
    queue_random(30);
    drain();

    // short limit, light idling on both sides
    write_reg(REG_MAX_LENGTH, 8'd20);
    send_idle_pct = 11;
    pop_stall_pct = 11;
    make_sentence(11, 0); queue_sentence();
    make_sentence(12, 0); queue_sentence();
    queue_random(30);
    drain();

    repeat (10) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
